// ===== src/nnc_pkg.sv =====
package nnc_pkg;

  // Fixed field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned ORG_W      = 10;

  // Arithmetic widths, sized for frame dimensions up to 4096
  localparam int unsigned EXT_W = 13;                 // extents and frame sizes
  localparam int unsigned DVS_W = EXT_W + 1;          // divisor, up to 2*frame size
  localparam int unsigned DVD_W = COORD_W + EXT_W;    // dividend from one 16x13 product

  // Operation codes
  localparam logic [OP_W-1:0] OP_STORE  = 2'd0;
  localparam logic [OP_W-1:0] OP_FETCH  = 2'd1;
  localparam logic [OP_W-1:0] OP_TO_SRC = 2'd2;
  localparam logic [OP_W-1:0] OP_TO_DST = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_ACTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_HEIGHT = 3'd4;

  // Register reset values
  localparam logic [9:0] CROP_WIDTH_RST  = 10'd640;
  localparam logic [8:0] CROP_HEIGHT_RST = 9'd480;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_DIV  = 6'b000100,
    S_FIN  = 6'b001000,
    S_MEM  = 6'b010000,
    S_RSP  = 6'b100000
  } state_e;

  // Divider lane control
  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// ===== src/nearest_neighbor_crop_scaler_core.sv =====
// Crop-and-upscale engine for an 8-bit indexed frame held in an on-chip store.
// Command channel: an op word (op_i, coord_x_i, coord_y_i, pixel_value_i) is
// taken at a clock edge with start_i high and busy_o low. busy_o stays high
// until the word's result is presented.
// Ops: store a pixel, fetch the scaled pixel at a presented point, map a
// presented point to the source frame, map a source point back.
// Result channel: every op gives one result word on out_x_o, out_y_o and
// out_pixel_o, marked by done_o, which is high for exactly one cycle; the
// receiver has no way to hold it off.
// done_o rises at the end of every op; busy_o falls in that same cycle, so the
// next word can be taken at the edge that ends the result cycle, and no new
// word is taken before the last one is through. The time is set by the
// two bit-serial dividers (x and y lanes, one quotient bit per cycle over 29
// bits) plus load, divider handoff, final map, store access and response.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// write it only while idle. Unknown indexes are ignored.
// Reset: control and config registers clear (full-frame crop, zoom off); the
// frame store is not cleared and must be written before it is fetched.
module nearest_neighbor_crop_scaler_core import nnc_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = 640,
  parameter int unsigned FRAME_HEIGHT = 480,
  parameter int unsigned LINE_PITCH   = 640
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [OP_W-1:0]              op_i,
  input  logic signed [COORD_W-1:0]    coord_x_i,
  input  logic signed [COORD_W-1:0]    coord_y_i,
  input  logic [PIX_W-1:0]             pixel_value_i,
  // result
  output logic                         done_o,
  output logic signed [COORD_W-1:0]    out_x_o,
  output logic signed [COORD_W-1:0]    out_y_o,
  output logic [PIX_W-1:0]             out_pixel_o,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned DEPTH  = LINE_PITCH * FRAME_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned AFULL_W = $clog2(DEPTH + FRAME_WIDTH);

  localparam logic [EXT_W-1:0] FULL_X = EXT_W'(FRAME_WIDTH);
  localparam logic [EXT_W-1:0] FULL_Y = EXT_W'(FRAME_HEIGHT);

  state_e state_q, state_d;

  // configuration registers
  logic       zoom_q;
  logic [9:0] left_q;
  logic [8:0] top_q;
  logic [9:0] cw_q;
  logic [8:0] ch_q;

  // captured command word
  logic [OP_W-1:0]           op_q;
  logic signed [COORD_W-1:0] crd_q [2];
  logic [PIX_W-1:0]          pix_q;

  // per-lane working values
  logic [EXT_W-1:0]   full_l [2];
  logic [EXT_W-1:0]   fm1_l  [2];
  logic [EXT_W-1:0]   ext_l  [2];
  logic [EXT_W-1:0]   cext   [2];
  logic [ORG_W-1:0]   org_l  [2];
  logic [COORD_W-1:0] clampc [2];
  logic signed [COORD_W:0] rel [2];
  logic [COORD_W-1:0] mul_a  [2];
  logic [EXT_W-1:0]   mul_b  [2];
  logic [DVD_W-1:0]   dvd    [2];
  logic [DVS_W-1:0]   dvs    [2];
  logic [DVD_W-1:0]   quo    [2];
  logic [COORD_W-1:0] fwd    [2];
  logic [COORD_W-1:0] back   [2];
  logic [COORD_W-1:0] mapped [2];
  logic [EXT_W-1:0]   loc    [2];
  logic               neg_q  [2];
  logic [COORD_W-1:0] res_q  [2];
  logic [EXT_W-1:0]   loc_q  [2];
  div_ctl_t           div_ctl [2];

  logic               wr_ok, wr_ok_q;
  logic [AFULL_W-1:0] addr_full;
  logic               in_range, rd_ok_q;
  logic               mem_we;
  logic [PIX_W-1:0]   rd_q;
  logic [PIX_W-1:0]   store_mem [DEPTH];
  logic               done_q;

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = !busy_o;

  // configuration writes, masked to register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q <= 1'b0;
      left_q <= '0;
      top_q  <= '0;
      cw_q   <= CROP_WIDTH_RST;
      ch_q   <= CROP_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ZOOM_ACTIVE: zoom_q <= cfg_data_i[0];
        REG_CROP_LEFT:   left_q <= cfg_data_i;
        REG_CROP_TOP:    top_q  <= cfg_data_i[8:0];
        REG_CROP_WIDTH:  cw_q   <= cfg_data_i;
        REG_CROP_HEIGHT: ch_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // lane constants and crop extents saturated to 1..frame size
  always_comb begin
    full_l[0] = FULL_X;
    full_l[1] = FULL_Y;
    org_l[0]  = left_q;
    org_l[1]  = {1'b0, top_q};
    cext[0]   = {3'b0, cw_q};
    cext[1]   = {4'b0, ch_q};
    for (int l = 0; l < 2; l++) begin
      fm1_l[l] = full_l[l] - 1'b1;
      if (cext[l] == '0) begin
        ext_l[l] = EXT_W'(1);
      end else if (cext[l] > full_l[l]) begin
        ext_l[l] = full_l[l];
      end else begin
        ext_l[l] = cext[l];
      end
    end
  end

  // divider operands: (2c+1)*ext / 2*full forward, rel*full / ext backward
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (crd_q[l] < 0) begin
        clampc[l] = '0;
      end else if (crd_q[l] > $signed({3'b0, fm1_l[l]})) begin
        clampc[l] = {3'b0, fm1_l[l]};
      end else begin
        clampc[l] = crd_q[l];
      end
      rel[l] = {crd_q[l][COORD_W-1], crd_q[l]} - $signed({7'b0, org_l[l]});
      if (op_q == OP_TO_DST) begin
        mul_a[l] = rel[l][COORD_W] ? '0 : rel[l][COORD_W-1:0];
        mul_b[l] = full_l[l];
        dvs[l]   = {1'b0, ext_l[l]};
      end else begin
        mul_a[l] = {clampc[l][COORD_W-2:0], 1'b1};
        mul_b[l] = ext_l[l];
        dvs[l]   = {full_l[l], 1'b0};
      end
      dvd[l] = mul_a[l] * mul_b[l];
    end
  end

  // one bit-serial divider per lane
  for (genvar g = 0; g < 2; g++) begin : g_lane
    assign div_ctl[g].start = (state_q == S_LOAD);
    nnc_div #(
      .DIVIDEND_W(DVD_W),
      .DIVISOR_W (DVS_W)
    ) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (div_ctl[g].start),
      .dividend_i(dvd[g]),
      .divisor_i (dvs[g]),
      .done_o    (div_ctl[g].done),
      .quotient_o(quo[g])
    );
  end

  // final mapping and clamp to frame
  always_comb begin
    wr_ok = 1'b1;
    for (int l = 0; l < 2; l++) begin
      fwd[l] = {6'b0, org_l[l]} + {3'b0, quo[l][EXT_W-1:0]};
      if (neg_q[l]) begin
        back[l] = '0;
      end else if (quo[l] > {{(DVD_W-EXT_W){1'b0}}, fm1_l[l]}) begin
        back[l] = {3'b0, fm1_l[l]};
      end else begin
        back[l] = quo[l][COORD_W-1:0];
      end
      if (zoom_q && (op_q != OP_STORE)) begin
        mapped[l] = (op_q == OP_TO_DST) ? back[l] : fwd[l];
      end else begin
        mapped[l] = crd_q[l];
      end
      if ($signed(mapped[l]) < 0) begin
        loc[l] = '0;
      end else if ($signed(mapped[l]) > $signed({3'b0, fm1_l[l]})) begin
        loc[l] = fm1_l[l];
      end else begin
        loc[l] = mapped[l][EXT_W-1:0];
      end
      wr_ok = wr_ok && !crd_q[l][COORD_W-1] && (crd_q[l] < $signed({3'b0, full_l[l]}));
    end
  end

  // store address from clamped row and column
  assign addr_full = AFULL_W'(loc_q[1]) * AFULL_W'(LINE_PITCH) + AFULL_W'(loc_q[0]);
  assign in_range  = addr_full < AFULL_W'(DEPTH);
  assign mem_we    = (state_q == S_MEM) && (op_q == OP_STORE) && wr_ok_q && in_range;

  // frame store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[addr_full[ADDR_W-1:0]] <= pix_q;
    end
    rd_q <= store_mem[addr_full[ADDR_W-1:0]];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_LOAD;
      S_LOAD: state_d = S_DIV;
      S_DIV:  if (div_ctl[0].done) state_d = S_FIN;
      S_FIN:  state_d = S_MEM;
      S_MEM:  state_d = S_RSP;
      S_RSP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_RSP);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      op_q     <= op_i;
      crd_q[0] <= coord_x_i;
      crd_q[1] <= coord_y_i;
      pix_q    <= pixel_value_i;
    end
    if (state_q == S_LOAD) begin
      neg_q[0] <= rel[0][COORD_W];
      neg_q[1] <= rel[1][COORD_W];
    end
    if (state_q == S_FIN) begin
      res_q   <= mapped;
      loc_q   <= loc;
      wr_ok_q <= wr_ok;
    end
    if (state_q == S_MEM) begin
      rd_ok_q <= in_range;
    end
    if (state_q == S_RSP) begin
      out_pixel_o <= ((op_q == OP_FETCH) && rd_ok_q) ? rd_q : '0;
      if ((op_q == OP_TO_SRC) || (op_q == OP_TO_DST)) begin
        out_x_o <= res_q[0];
        out_y_o <= res_q[1];
      end else begin
        out_x_o <= '0;
        out_y_o <= '0;
      end
    end
  end

  assign done_o = done_q;

  // both divider lanes run in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl[0].done == div_ctl[1].done)
    else $error("divider lanes out of step");

  // a result word only follows the response state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == S_RSP) && !busy_o)
    else $error("result word outside response slot");

  // store writes stay inside the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (addr_full < AFULL_W'(DEPTH)) && (op_q == OP_STORE))
    else $error("store write out of range");

  // divider finishes only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl[0].done |-> (state_q == S_DIV))
    else $error("divider done outside divide state");

endmodule

// ===== src/nnc_div.sv =====
module nnc_div import nnc_pkg::*; #(
  parameter int unsigned DIVIDEND_W = 29,
  parameter int unsigned DIVISOR_W  = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic                  run_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    shifted, diff;
  logic                  ge;

  // one restoring step: bring down next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_q, quo_q[DIVIDEND_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
    rem_d   = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    quo_d   = {quo_q[DIVIDEND_W-2:0], ge};
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
